// ===== hdl/quaternion_scale_position_to_matrix_core_defines.svh =====
// ---------------------------------------------------------------------------
// Quaternion/scale/position to matrix - assertion macros
// Shared macros for concurrent checks on the transform core.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_SCALE_POSITION_TO_MATRIX_CORE_DEFINES_SVH
`define QUATERNION_SCALE_POSITION_TO_MATRIX_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define QSPM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");

// Implication: when ante holds, cons holds at the same edge.
`define QSPM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Implication: when ante holds, cons holds at the next edge.
`define QSPM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hdl/qspm_pkg.sv =====
// ---------------------------------------------------------------------------
// qspm_pkg
// Widths, constants and helpers for the quaternion-to-matrix transform core.
// ---------------------------------------------------------------------------
package qspm_pkg;

  localparam int DATA_W  = 32;                 // every port field
  localparam int FRAC_W  = 30;                 // Q1.30 quaternion fraction
  localparam int PROD_W  = 2 * DATA_W - FRAC_W; // quaternion product after >>30
  localparam int TERM_W  = PROD_W + 3;          // rotation term, Q.30
  localparam int SPLIT_W = 16;                 // low slice of the term
  localparam int HI_W    = TERM_W - SPLIT_W;   // high slice, signed
  localparam int PH_W    = HI_W + DATA_W;      // high partial product
  localparam int PL_W    = SPLIT_W + 1 + DATA_W; // low partial product
  localparam int SUM_W   = PH_W + SPLIT_W;     // full term * scale
  localparam int SH_W    = SUM_W - FRAC_W;     // after >>30
  localparam int NSTAGE  = 5;
  localparam int NELEM   = 9;

  localparam logic signed [TERM_W-1:0] ONE_Q30 =
    {{(TERM_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

  // load enables for the three element stages
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } elem_ld_t;

  // product of two Q1.30 values, floored to Q.30
  function automatic logic signed [PROD_W-1:0] qmul(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [2*DATA_W-1:0] p;
    p = a * b;
    return p[2*DATA_W-1:FRAC_W];
  endfunction

  function automatic logic signed [TERM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
    return {{(TERM_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  // 1 - 2(a+b)
  function automatic logic signed [TERM_W-1:0] term_diag(
    input logic signed [PROD_W-1:0] a,
    input logic signed [PROD_W-1:0] b
  );
    logic signed [TERM_W-1:0] s;
    s = ext(a) + ext(b);
    return ONE_Q30 - (s <<< 1);
  endfunction

  // 2(a+b)
  function automatic logic signed [TERM_W-1:0] term_add(
    input logic signed [PROD_W-1:0] a,
    input logic signed [PROD_W-1:0] b
  );
    logic signed [TERM_W-1:0] s;
    s = ext(a) + ext(b);
    return s <<< 1;
  endfunction

  // 2(a-b)
  function automatic logic signed [TERM_W-1:0] term_sub(
    input logic signed [PROD_W-1:0] a,
    input logic signed [PROD_W-1:0] b
  );
    logic signed [TERM_W-1:0] s;
    s = ext(a) - ext(b);
    return s <<< 1;
  endfunction

endpackage

// ===== hdl/qspm_elem.sv =====
// ---------------------------------------------------------------------------
// qspm_elem
// One matrix element: rotation term times scale, floored and saturated.
// Three stages: split multiply, recombine and shift, saturate.
// ---------------------------------------------------------------------------
module qspm_elem (
  input  logic                                  clk_i,
  input  qspm_pkg::elem_ld_t                    ld_i,
  input  logic signed [qspm_pkg::TERM_W-1:0]    term_i,
  input  logic signed [qspm_pkg::DATA_W-1:0]    scale_i,
  output logic signed [qspm_pkg::DATA_W-1:0]    elem_o
);
  import qspm_pkg::*;

  logic signed [HI_W-1:0]      term_hi;
  logic signed [SPLIT_W:0]     term_lo;
  logic signed [PH_W-1:0]      ph_d, ph_q;
  logic signed [PL_W-1:0]      pl_d, pl_q;
  logic signed [SUM_W-1:0]     sum;
  logic signed [SH_W-1:0]      sh_d, sh_q;
  logic signed [DATA_W-1:0]    elem_d, elem_q;

  // term = hi * 2^16 + lo, lo unsigned
  assign term_hi = term_i[TERM_W-1:SPLIT_W];
  assign term_lo = {1'b0, term_i[SPLIT_W-1:0]};
  assign ph_d    = term_hi * scale_i;
  assign pl_d    = term_lo * scale_i;

  assign sum  = {ph_q, {SPLIT_W{1'b0}}} + {{(SUM_W-PL_W){pl_q[PL_W-1]}}, pl_q};
  assign sh_d = sum[SUM_W-1:FRAC_W];  // floor

  always_comb begin
    if (sh_q[SH_W-1:DATA_W-1] == {(SH_W-DATA_W+1){sh_q[SH_W-1]}}) begin
      elem_d = sh_q[DATA_W-1:0];
    end else if (sh_q[SH_W-1]) begin
      elem_d = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      elem_d = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      ph_q <= ph_d;
      pl_q <= pl_d;
    end
    if (ld_i.s4) begin
      sh_q <= sh_d;
    end
    if (ld_i.s5) begin
      elem_q <= elem_d;
    end
  end

  assign elem_o = elem_q;

endmodule

// ===== hdl/quaternion_scale_position_to_matrix_core.sv =====
// ---------------------------------------------------------------------------
// quaternion_scale_position_to_matrix_core
// Quaternion, per-axis scale and position to the nine rotation-scale
// elements and the translation row of a row-major transform, fixed point.
// ---------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | to core   | in_valid_i / in_stall_o | quat_*, scale_*, pos_*
//  out     | from core | out_valid_o / out_stall_i | m00..m22, trans_*
//
//  One request per cycle sustained while the output is not stalled.
//  Stages: quaternion products, rotation terms, term x scale split multiply,
//  recombine and floor, saturate into the output register.
//  Each stage loads when empty or when the stage after it moves, so bubbles
//  collapse; while a result is stalled the input keeps taking requests until
//  all five stages are full, then stalls with the output.
//  Reset clears the stage valid bits only.
// ---------------------------------------------------------------------------
module quaternion_scale_position_to_matrix_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [qspm_pkg::DATA_W-1:0] quat_x_i,
  input  logic signed [qspm_pkg::DATA_W-1:0] quat_y_i,
  input  logic signed [qspm_pkg::DATA_W-1:0] quat_z_i,
  input  logic signed [qspm_pkg::DATA_W-1:0] quat_w_i,
  input  logic signed [qspm_pkg::DATA_W-1:0] scale_x_i,
  input  logic signed [qspm_pkg::DATA_W-1:0] scale_y_i,
  input  logic signed [qspm_pkg::DATA_W-1:0] scale_z_i,
  input  logic signed [qspm_pkg::DATA_W-1:0] pos_x_i,
  input  logic signed [qspm_pkg::DATA_W-1:0] pos_y_i,
  input  logic signed [qspm_pkg::DATA_W-1:0] pos_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [qspm_pkg::DATA_W-1:0] m00_o,
  output logic signed [qspm_pkg::DATA_W-1:0] m01_o,
  output logic signed [qspm_pkg::DATA_W-1:0] m02_o,
  output logic signed [qspm_pkg::DATA_W-1:0] m10_o,
  output logic signed [qspm_pkg::DATA_W-1:0] m11_o,
  output logic signed [qspm_pkg::DATA_W-1:0] m12_o,
  output logic signed [qspm_pkg::DATA_W-1:0] m20_o,
  output logic signed [qspm_pkg::DATA_W-1:0] m21_o,
  output logic signed [qspm_pkg::DATA_W-1:0] m22_o,
  output logic signed [qspm_pkg::DATA_W-1:0] trans_x_o,
  output logic signed [qspm_pkg::DATA_W-1:0] trans_y_o,
  output logic signed [qspm_pkg::DATA_W-1:0] trans_z_o
);
  import qspm_pkg::*;

  logic [NSTAGE-1:0] valid_d, valid_q;
  logic [NSTAGE-1:0] ld;
  elem_ld_t          elem_ld;

  // stage 1: quaternion products
  logic signed [PROD_W-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  // stage 2: rotation terms, row-major
  logic signed [TERM_W-1:0] term_d [NELEM];
  logic signed [TERM_W-1:0] term_q [NELEM];
  logic signed [DATA_W-1:0] elem   [NELEM];

  // scale rides along for stages 1 and 2, position for all five
  logic signed [DATA_W-1:0] scl_q [2][3];
  logic signed [DATA_W-1:0] pos_q [NSTAGE][3];

  // load chain from the output back to the input
  always_comb begin
    ld[NSTAGE-1] = !valid_q[NSTAGE-1] || !out_stall_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      ld[k] = !valid_q[k] || ld[k+1];
    end
  end

  assign in_stall_o = !ld[0];
  assign elem_ld    = '{s3: ld[2], s4: ld[3], s5: ld[4]};

  always_comb begin
    valid_d = valid_q;
    for (int k = 0; k < NSTAGE; k++) begin
      if (ld[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_comb begin
    term_d[0] = term_diag(yy_q, zz_q);
    term_d[1] = term_add(xy_q, wz_q);
    term_d[2] = term_sub(xz_q, wy_q);
    term_d[3] = term_sub(xy_q, wz_q);
    term_d[4] = term_diag(xx_q, zz_q);
    term_d[5] = term_add(yz_q, wx_q);
    term_d[6] = term_add(xz_q, wy_q);
    term_d[7] = term_sub(yz_q, wx_q);
    term_d[8] = term_diag(xx_q, yy_q);
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      xx_q <= qmul(quat_x_i, quat_x_i);
      yy_q <= qmul(quat_y_i, quat_y_i);
      zz_q <= qmul(quat_z_i, quat_z_i);
      xy_q <= qmul(quat_x_i, quat_y_i);
      xz_q <= qmul(quat_x_i, quat_z_i);
      yz_q <= qmul(quat_y_i, quat_z_i);
      wx_q <= qmul(quat_w_i, quat_x_i);
      wy_q <= qmul(quat_w_i, quat_y_i);
      wz_q <= qmul(quat_w_i, quat_z_i);
      scl_q[0] <= '{scale_x_i, scale_y_i, scale_z_i};
      pos_q[0] <= '{pos_x_i, pos_y_i, pos_z_i};
    end
    if (ld[1]) begin
      term_q   <= term_d;
      scl_q[1] <= scl_q[0];
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (ld[k]) begin
        pos_q[k] <= pos_q[k-1];
      end
    end
  end

  // element (r,c) takes scale component c
  for (genvar e = 0; e < NELEM; e++) begin : g_elem
    qspm_elem u_elem (
      .clk_i   (clk_i),
      .ld_i    (elem_ld),
      .term_i  (term_q[e]),
      .scale_i (scl_q[1][e % 3]),
      .elem_o  (elem[e])
    );
  end

  assign out_valid_o = valid_q[NSTAGE-1];
  assign m00_o = elem[0];
  assign m01_o = elem[1];
  assign m02_o = elem[2];
  assign m10_o = elem[3];
  assign m11_o = elem[4];
  assign m12_o = elem[5];
  assign m20_o = elem[6];
  assign m21_o = elem[7];
  assign m22_o = elem[8];
  assign trans_x_o = pos_q[NSTAGE-1][0];
  assign trans_y_o = pos_q[NSTAGE-1][1];
  assign trans_z_o = pos_q[NSTAGE-1][2];

endmodule

// ===== hdl/qspm_checker.sv =====
// ---------------------------------------------------------------------------
// qspm_checker
// Port-level checks on the transform core, attached by bind.
// ---------------------------------------------------------------------------
`include "quaternion_scale_position_to_matrix_core_defines.svh"

module qspm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] pos_x_i,
  input logic [31:0] trans_x_o,
  input logic [31:0] m00_o
);

  // a stalled result stays offered
  `QSPM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // a stalled result keeps its payload
  `QSPM_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(trans_x_o) && $stable(m00_o))

  // with an empty output register the pipeline always takes a request
  `QSPM_ASSERT_IMP(a_no_false_stall, clk_i, rst_ni, !out_valid_o, !in_stall_o)

  // five stages with no stall in between: the request shows up in order
  `QSPM_ASSERT_IMP(a_latency, clk_i, rst_ni, $past(rst_ni, 5) && $past(in_valid_i && !in_stall_o, 5) && !$past(out_stall_i, 1) && !$past(out_stall_i, 2) && !$past(out_stall_i, 3) && !$past(out_stall_i, 4), out_valid_o && (trans_x_o == $past(pos_x_i, 5)))

endmodule

bind quaternion_scale_position_to_matrix_core qspm_checker u_qspm_checker (.*);
